// ----- sv/nggp_pkg.sv -----
// Shared types and constants for the GGA time/position parser.
// Used by the front classifier, the command queue, the back end and the top level.
`default_nettype none

package nggp_pkg;

	// Commands passed from the front classifier to the back end
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_TIME,
		OP_LAT,
		OP_LON,
		OP_END_TIME,
		OP_END_LAT,
		OP_START_LON,
		OP_END_LON
	} op_t;

	typedef enum logic [1:0] {
		CL_DIGIT,
		CL_POINT,
		CL_OTHER
	} cls_t;

	typedef struct packed {
		op_t        op;
		cls_t       cls;
		logic [3:0] digit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int QDEPTH = 8;
	localparam int QAW    = 3;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Field numbers, counted by commas since the dollar sign
	localparam logic [2:0] FLD_TIME = 3'd1;
	localparam logic [2:0] FLD_LAT  = 3'd2;
	localparam logic [2:0] FLD_NS   = 3'd3;
	localparam logic [2:0] FLD_LON  = 3'd4;
	localparam logic [2:0] FLD_EW   = 3'd5;

	localparam logic [2:0] TIME_CHARS = 3'd6;

	localparam int TW   = 7;
	localparam int LATW = 30;
	localparam int LONW = 34;
	localparam int MACW = LONW + 4;

	localparam logic [LATW-1:0] LAT_MAX = 30'd999999999;
	localparam logic [LONW-1:0] LON_MAX = 34'd9999999999;

endpackage

`default_nettype wire

// ----- sv/nggp_front.sv -----
// Front end: accepts characters, tracks sentence and field position, and turns
// each relevant character into a command. Depends on nggp_pkg.
`default_nettype none

module nggp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,   // [7:0] char_in
	input  wire                  q_full,
	output logic                 push,
	output nggp_pkg::cmd_t       cmd
);

	logic       in_sent_q;
	logic [2:0] comma_q;
	logic [2:0] comma_nxt;
	logic       acc;
	logic       want;
	logic       is_digit;

	assign s_tready  = !q_full;
	assign acc       = s_tvalid && !q_full;
	assign comma_nxt = comma_q + 3'd1;
	assign is_digit  = (s_tdata >= nggp_pkg::CH_ZERO) && (s_tdata <= nggp_pkg::CH_NINE);

	always_comb begin
		want      = 1'b0;
		cmd.op    = nggp_pkg::OP_CLEAR;
		cmd.digit = is_digit ? s_tdata[3:0] : 4'd0;
		if (is_digit) begin
			cmd.cls = nggp_pkg::CL_DIGIT;
		end else if (s_tdata == nggp_pkg::CH_POINT) begin
			cmd.cls = nggp_pkg::CL_POINT;
		end else begin
			cmd.cls = nggp_pkg::CL_OTHER;
		end

		priority if (s_tdata == nggp_pkg::CH_DOLLAR) begin
			want   = 1'b1;
			cmd.op = nggp_pkg::OP_CLEAR;
		end else if (in_sent_q && s_tdata == nggp_pkg::CH_COMMA) begin
			case (comma_nxt)
				nggp_pkg::FLD_LAT: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_END_TIME;
				end
				nggp_pkg::FLD_NS: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_END_LAT;
				end
				nggp_pkg::FLD_LON: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_START_LON;
				end
				nggp_pkg::FLD_EW: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_END_LON;
				end
				default: want = 1'b0;
			endcase
		end else if (in_sent_q) begin
			case (comma_q)
				nggp_pkg::FLD_TIME: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_TIME;
				end
				nggp_pkg::FLD_LAT: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_LAT;
				end
				nggp_pkg::FLD_LON: begin
					want   = 1'b1;
					cmd.op = nggp_pkg::OP_LON;
				end
				default: want = 1'b0;
			endcase
		end else begin
			// drop characters outside a sentence
			want = 1'b0;
		end
	end

	assign push = acc && want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			comma_q   <= 3'd0;
		end else if (acc) begin
			if (s_tdata == nggp_pkg::CH_DOLLAR) begin
				in_sent_q <= 1'b1;
				comma_q   <= 3'd0;
			end else if (in_sent_q && s_tdata == nggp_pkg::CH_COMMA) begin
				comma_q <= comma_nxt;
				// sentence ends with the field after longitude
				if (comma_nxt == nggp_pkg::FLD_EW) begin
					in_sent_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/nggp_cmd_fifo.sv -----
// Short command queue between the front classifier and the back end.
// Depends on nggp_pkg for the command type and queue depth.
`default_nettype none

module nggp_cmd_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  nggp_pkg::cmd_t       wr_cmd,
	input  wire                  pop,
	output nggp_pkg::cmd_t       rd_cmd,
	output nggp_pkg::q_stat_t    stat
);

	nggp_pkg::cmd_t       mem_q [nggp_pkg::QDEPTH];
	logic [nggp_pkg::QAW-1:0] wr_q;
	logic [nggp_pkg::QAW-1:0] rd_q;
	logic [nggp_pkg::QAW:0]   cnt_q;
	logic                     do_push;
	logic                     do_pop;

	assign stat.full  = (cnt_q == (nggp_pkg::QAW+1)'(nggp_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_cmd     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/nggp_back.sv -----
// Back end: executes commands on the time digits, with their own times-ten adder, and on the two
// fixed-point accumulators through one shared times-ten unit, and holds the result register.
// Depends on nggp_pkg.
`default_nettype none

module nggp_back #(
	parameter int FRACTION_DIGITS = 5
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  nggp_pkg::cmd_t               cmd,
	input  wire                          cmd_valid,
	output logic                         pop,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [nggp_pkg::TW-1:0]      hour,
	output logic [nggp_pkg::TW-1:0]      minute,
	output logic [nggp_pkg::TW-1:0]      second,
	output logic [nggp_pkg::LATW-1:0]    latitude_fixed,
	output logic [nggp_pkg::LONW-1:0]    longitude_fixed,
	output logic                         bad_digit,
	output logic                         saturated
);

	localparam int FW = $clog2(FRACTION_DIGITS + 1);
	localparam logic [FW-1:0] FD_N = FW'(FRACTION_DIGITS);

	logic [nggp_pkg::TW-1:0]   hour_q, min_q, sec_q;
	logic [nggp_pkg::TW-1:0]   hour_d, min_d, sec_d;
	logic [2:0]                pos_q, pos_d;
	logic [nggp_pkg::LATW-1:0] lat_q, lat_d;
	logic [nggp_pkg::LONW-1:0] lon_q, lon_d;
	logic                      point_q, point_d;
	logic [FW-1:0]             frac_q, frac_d;
	logic                      bad_q, bad_d;
	logic                      sat_q, sat_d;
	logic                      out_valid_q;
	logic                      load;
	logic                      out_free;

	logic                      use_lon;
	logic                      pad_op;
	logic [nggp_pkg::LONW-1:0] mac_acc;
	logic [nggp_pkg::LONW-1:0] mac_max;
	logic [3:0]                mac_dig;
	logic [nggp_pkg::MACW-1:0] mac_prod;
	logic                      mac_ovf;
	logic [nggp_pkg::LONW-1:0] mac_res;

	logic [nggp_pkg::TW-1:0]   slot_v;
	logic [3:0]                t_dig;
	logic [10:0]               t_sum;
	logic [nggp_pkg::TW-1:0]   t_res;
	logic                      time_open;
	logic                      frac_open;
	logic                      take_digit;

	assign out_free  = !out_valid_q || m_tready;
	assign time_open = pos_q < nggp_pkg::TIME_CHARS;
	assign frac_open = frac_q < FD_N;

	// shared multiply-by-ten-and-add with saturation
	assign use_lon = (cmd.op == nggp_pkg::OP_LON) || (cmd.op == nggp_pkg::OP_END_LON);
	assign pad_op  = (cmd.op == nggp_pkg::OP_END_LAT) || (cmd.op == nggp_pkg::OP_END_LON);
	assign mac_acc = use_lon ? lon_q : nggp_pkg::LONW'(lat_q);
	assign mac_max = use_lon ? nggp_pkg::LON_MAX : nggp_pkg::LONW'(nggp_pkg::LAT_MAX);
	assign mac_dig = pad_op ? 4'd0 : cmd.digit;
	assign mac_prod = {1'b0, mac_acc, 3'b000} + {3'b000, mac_acc, 1'b0}
		+ nggp_pkg::MACW'(mac_dig);
	assign mac_ovf = mac_prod > nggp_pkg::MACW'(mac_max);
	assign mac_res = mac_ovf ? mac_max : mac_prod[nggp_pkg::LONW-1:0];

	// time digit pair update, wraps to seven bits
	always_comb begin
		unique case (pos_q[2:1])
			2'd0:    slot_v = hour_q;
			2'd1:    slot_v = min_q;
			default: slot_v = sec_q;
		endcase
	end
	assign t_dig = (cmd.op == nggp_pkg::OP_TIME && cmd.cls == nggp_pkg::CL_DIGIT) ?
		cmd.digit : 4'd0;
	assign t_sum = {1'b0, slot_v, 3'b000} + {3'b000, slot_v, 1'b0} + 11'(t_dig);
	assign t_res = t_sum[nggp_pkg::TW-1:0];

	assign take_digit = !point_q || frac_open;

	always_comb begin
		hour_d  = hour_q;
		min_d   = min_q;
		sec_d   = sec_q;
		pos_d   = pos_q;
		lat_d   = lat_q;
		lon_d   = lon_q;
		point_d = point_q;
		frac_d  = frac_q;
		bad_d   = bad_q;
		sat_d   = sat_q;
		pop     = 1'b0;
		load    = 1'b0;

		if (cmd_valid) begin
			unique case (cmd.op)
				nggp_pkg::OP_CLEAR: begin
					hour_d  = '0;
					min_d   = '0;
					sec_d   = '0;
					pos_d   = '0;
					lat_d   = '0;
					lon_d   = '0;
					point_d = 1'b0;
					frac_d  = '0;
					bad_d   = 1'b0;
					sat_d   = 1'b0;
					pop     = 1'b1;
				end
				nggp_pkg::OP_TIME, nggp_pkg::OP_END_TIME: begin
					if (time_open) begin
						unique case (pos_q[2:1])
							2'd0:    hour_d = t_res;
							2'd1:    min_d  = t_res;
							default: sec_d  = t_res;
						endcase
						pos_d = pos_q + 3'd1;
						if (cmd.op == nggp_pkg::OP_END_TIME || cmd.cls != nggp_pkg::CL_DIGIT) begin
							bad_d = 1'b1;
						end
					end
					// padding: hold the comma until all six time digits are in
					if (cmd.op == nggp_pkg::OP_TIME) begin
						pop = 1'b1;
					end else if (!time_open) begin
						point_d = 1'b0;
						frac_d  = '0;
						pop     = 1'b1;
					end
				end
				nggp_pkg::OP_LAT, nggp_pkg::OP_LON: begin
					pop = 1'b1;
					unique case (cmd.cls)
						nggp_pkg::CL_DIGIT: begin
							if (take_digit) begin
								if (use_lon) begin
									lon_d = mac_res;
								end else begin
									lat_d = mac_res[nggp_pkg::LATW-1:0];
								end
								sat_d = sat_q | mac_ovf;
								if (point_q) begin
									frac_d = frac_q + 1'b1;
								end
							end
						end
						nggp_pkg::CL_POINT: begin
							if (point_q) begin
								bad_d = 1'b1;
							end else begin
								point_d = 1'b1;
							end
						end
						default: bad_d = 1'b1;
					endcase
				end
				nggp_pkg::OP_END_LAT: begin
					if (frac_open) begin
						lat_d  = mac_res[nggp_pkg::LATW-1:0];
						sat_d  = sat_q | mac_ovf;
						frac_d = frac_q + 1'b1;
					end else begin
						pop = 1'b1;
					end
				end
				nggp_pkg::OP_START_LON: begin
					point_d = 1'b0;
					frac_d  = '0;
					pop     = 1'b1;
				end
				nggp_pkg::OP_END_LON: begin
					if (frac_open) begin
						lon_d  = mac_res;
						sat_d  = sat_q | mac_ovf;
						frac_d = frac_q + 1'b1;
					end else if (out_free) begin
						load = 1'b1;
						pop  = 1'b1;
					end
				end
				default: pop = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q      <= '0;
			min_q       <= '0;
			sec_q       <= '0;
			pos_q       <= '0;
			lat_q       <= '0;
			lon_q       <= '0;
			point_q     <= 1'b0;
			frac_q      <= '0;
			bad_q       <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hour_q  <= hour_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			pos_q   <= pos_d;
			lat_q   <= lat_d;
			lon_q   <= lon_d;
			point_q <= point_d;
			frac_q  <= frac_d;
			bad_q   <= bad_d;
			sat_q   <= sat_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hour            <= hour_q;
			minute          <= min_q;
			second          <= sec_q;
			latitude_fixed  <= lat_q;
			longitude_fixed <= lon_q;
			bad_digit       <= bad_q;
			saturated       <= sat_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/nmea_gga_time_position_parser.sv -----
// GGA time/position parser top level: front classifier, command queue, back end.
// Takes one character per cycle while the command queue has room. At field-closing commas
// the back end pads missing time or fraction digits, holding the comma at the queue head
// (the queue hides most of this). The result register loads when the closing comma is
// executed, after padding and any queue backlog. Reset clears all parser and queue state.
// Depends on nggp_pkg, nggp_front, nggp_cmd_fifo and nggp_back.
`default_nettype none

module nmea_gga_time_position_parser #(
	parameter int FRACTION_DIGITS = 5
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // [7:0] char_in
	output logic         m_tvalid,
	input  wire          m_tready,
	// [6:0] hour, [13:7] minute, [20:14] second, [50:21] latitude_fixed,
	// [84:51] longitude_fixed, [87:85] zero
	output logic [87:0]  m_tdata,
	output logic [1:0]   m_tuser    // [0] bad_digit, [1] saturated
);

	nggp_pkg::cmd_t    push_cmd;
	nggp_pkg::cmd_t    head_cmd;
	nggp_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	logic [nggp_pkg::TW-1:0]   hour;
	logic [nggp_pkg::TW-1:0]   minute;
	logic [nggp_pkg::TW-1:0]   second;
	logic [nggp_pkg::LATW-1:0] latitude_fixed;
	logic [nggp_pkg::LONW-1:0] longitude_fixed;
	logic                      bad_digit;
	logic                      saturated;

	nggp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_stat.full),
		.push     (push),
		.cmd      (push_cmd)
	);

	nggp_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	nggp_back #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (head_cmd),
		.cmd_valid       (!q_stat.empty),
		.pop             (pop),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.hour            (hour),
		.minute          (minute),
		.second          (second),
		.latitude_fixed  (latitude_fixed),
		.longitude_fixed (longitude_fixed),
		.bad_digit       (bad_digit),
		.saturated       (saturated)
	);

	assign m_tdata = {3'b000, longitude_fixed, latitude_fixed, second, minute, hour};
	assign m_tuser = {saturated, bad_digit};

	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("back end consumed from an empty queue");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (latitude_fixed <= nggp_pkg::LAT_MAX))
		else $error("latitude above saturation limit");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (longitude_fixed <= nggp_pkg::LON_MAX))
		else $error("longitude above saturation limit");

endmodule

`default_nettype wire

// ----- test/nmea_gga_time_position_parser_tb.sv -----
// Self-checking testbench for the GGA time/position parser: streams sentence characters,
// predicts each time/latitude/longitude fix in step with the input and compares every result.
// Depends on nggp_pkg and nmea_gga_time_position_parser.
`timescale 1ns / 100ps

module nmea_gga_time_position_parser_tb;

	localparam int FRAC_DIGITS = 5;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] lat;
		logic [33:0] lon;
		logic        bad;
		logic        sat;
	} gga_fix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [7:0] char_queue [$];
	gga_fix_t   expected_fixes [$];
	bit         char_accepted = 1'b0;
	bit         steady = 1'b0;
	bit         hold_start = 1'b0;
	int         hold_left = 0;
	int         fail_count = 0;
	int         cycle_count = 0;

	// Parser shadow state
	logic        in_sent;
	logic [2:0]  field_no;
	int unsigned time_pos;
	logic [6:0]  time_pair [3];
	logic [63:0] lat_acc;
	logic [63:0] lon_acc;
	logic        point_done;
	int unsigned frac_cnt;
	logic        bad_flag;
	logic        sat_flag;

	nmea_gga_time_position_parser #(
		.FRACTION_DIGITS(FRAC_DIGITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_parser();
		in_sent = 1'b0;
		field_no = 3'd0;
		time_pos = 0;
		foreach (time_pair[i]) time_pair[i] = 7'd0;
		lat_acc = 64'd0;
		lon_acc = 64'd0;
		point_done = 1'b0;
		frac_cnt = 0;
		bad_flag = 1'b0;
		sat_flag = 1'b0;
	endtask

	// Multiply-by-ten accumulate; stick at the limit on overflow
	task automatic push_decimal(inout logic [63:0] acc, input logic [3:0] d,
		input logic [63:0] lim);
		if (acc > (lim - d) / 10) begin
			sat_flag = 1'b1;
			acc = lim;
		end else begin
			acc = acc * 10 + d;
		end
	endtask

	task automatic put_time_digit(input logic [3:0] d);
		time_pair[time_pos / 2] = 7'(time_pair[time_pos / 2] * 10 + d);
		time_pos++;
	endtask

	task automatic position_char(inout logic [63:0] acc, input logic [7:0] c,
		input logic [63:0] lim);
		if (c >= nggp_pkg::CH_ZERO && c <= nggp_pkg::CH_NINE) begin
			if (!point_done) begin
				push_decimal(acc, 4'(c - nggp_pkg::CH_ZERO), lim);
			end else if (frac_cnt < FRAC_DIGITS) begin
				push_decimal(acc, 4'(c - nggp_pkg::CH_ZERO), lim);
				frac_cnt++;
			end
		end else if (c == nggp_pkg::CH_POINT && !point_done) begin
			point_done = 1'b1;
		end else begin
			bad_flag = 1'b1;
		end
	endtask

	// Pad the missing fraction digits with zeros
	task automatic close_field(inout logic [63:0] acc, input logic [63:0] lim);
		for (int i = frac_cnt; i < FRAC_DIGITS; i++) push_decimal(acc, 4'd0, lim);
	endtask

	task automatic parse_char(input logic [7:0] c);
		gga_fix_t fix;
		if (c == nggp_pkg::CH_DOLLAR) begin
			clear_parser();
			in_sent = 1'b1;
		end else if (in_sent) begin
			if (c == nggp_pkg::CH_COMMA) begin
				field_no = field_no + 3'd1;
				case (field_no)
					nggp_pkg::FLD_LAT: begin
						if (time_pos < nggp_pkg::TIME_CHARS) bad_flag = 1'b1;
						while (time_pos < nggp_pkg::TIME_CHARS) put_time_digit(4'd0);
						point_done = 1'b0;
						frac_cnt = 0;
					end
					nggp_pkg::FLD_NS: close_field(lat_acc, nggp_pkg::LAT_MAX);
					nggp_pkg::FLD_LON: begin
						point_done = 1'b0;
						frac_cnt = 0;
					end
					nggp_pkg::FLD_EW: begin
						close_field(lon_acc, nggp_pkg::LON_MAX);
						fix.hour = time_pair[0];
						fix.minute = time_pair[1];
						fix.second = time_pair[2];
						fix.lat = lat_acc[29:0];
						fix.lon = lon_acc[33:0];
						fix.bad = bad_flag;
						fix.sat = sat_flag;
						expected_fixes.push_back(fix);
						in_sent = 1'b0;
					end
					default: ;
				endcase
			end else begin
				case (field_no)
					nggp_pkg::FLD_TIME: begin
						if (time_pos < nggp_pkg::TIME_CHARS) begin
							if (c >= nggp_pkg::CH_ZERO && c <= nggp_pkg::CH_NINE) begin
								put_time_digit(4'(c - nggp_pkg::CH_ZERO));
							end else begin
								bad_flag = 1'b1;
								put_time_digit(4'd0);
							end
						end
					end
					nggp_pkg::FLD_LAT: position_char(lat_acc, c, nggp_pkg::LAT_MAX);
					nggp_pkg::FLD_LON: position_char(lon_acc, c, nggp_pkg::LON_MAX);
					default: ;
				endcase
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Sender: hold a request until taken, then offer the next character or idle
	always @(negedge clk) begin
		if (!(s_tvalid && !char_accepted)) begin
			char_accepted = 1'b0;
			if (char_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 29)) begin
				s_tvalid <= 1'b1;
				s_tdata <= char_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	always @(posedge clk) begin : monitor_blk
		gga_fix_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_fixes.size() == 0) begin
					$error("result with no sentence pending: tdata %h tuser %b", m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = expected_fixes.pop_front();
					check_field("hour", want.hour, m_tdata[6:0]);
					check_field("minute", want.minute, m_tdata[13:7]);
					check_field("second", want.second, m_tdata[20:14]);
					check_field("latitude_fixed", want.lat, m_tdata[50:21]);
					check_field("longitude_fixed", want.lon, m_tdata[84:51]);
					check_field("bad_digit", want.bad, m_tuser[0]);
					check_field("saturated", want.sat, m_tuser[1]);
				end
			end
			// A fix never leaves in the cycle its closing comma enters
			if (s_tvalid && s_tready) begin
				char_accepted = 1'b1;
				parse_char(s_tdata);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_text(input string s);
		foreach (s[i]) char_queue.push_back(s[i]);
	endtask

	task automatic add_digits(ref logic [7:0] buf_q [$], input int n, input bit nines);
		repeat (n) buf_q.push_back(nines ? "9" : 8'(nggp_pkg::CH_ZERO + $urandom_range(0, 9)));
	endtask

	function automatic logic [7:0] junk_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == nggp_pkg::CH_DOLLAR || b == nggp_pkg::CH_COMMA);
		return b;
	endfunction

	task automatic add_position(ref logic [7:0] buf_q [$], input int max_int);
		int  n_int;
		bit  nines;
		nines = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) == 0) n_int = max_int + $urandom_range(1, 4);
		else n_int = $urandom_range(0, max_int);
		add_digits(buf_q, n_int, nines);
		if ($urandom_range(0, 3) != 0) begin
			buf_q.push_back(nggp_pkg::CH_POINT);
			add_digits(buf_q, $urandom_range(0, 7), nines);
		end
		if ($urandom_range(0, 9) == 0) buf_q.push_back(junk_char());
		if ($urandom_range(0, 14) == 0) begin
			buf_q.push_back(nggp_pkg::CH_POINT);
			add_digits(buf_q, $urandom_range(0, 2), nines);
		end
	endtask

	task automatic add_sentence();
		logic [7:0] s [$];
		int         cut;
		s.push_back(nggp_pkg::CH_DOLLAR);
		repeat ($urandom_range(0, 5)) s.push_back(8'($urandom_range(65, 90)));
		s.push_back(nggp_pkg::CH_COMMA);
		if ($urandom_range(0, 99) < 80) begin
			add_digits(s, 6, 1'b0);
			if ($urandom_range(0, 2) == 0) begin
				s.push_back(nggp_pkg::CH_POINT);
				add_digits(s, $urandom_range(0, 3), 1'b0);
			end
		end else begin
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 2) == 0) s.push_back(junk_char());
				else add_digits(s, 1, 1'b0);
			end
		end
		s.push_back(nggp_pkg::CH_COMMA);
		add_position(s, 4);
		s.push_back(nggp_pkg::CH_COMMA);
		if ($urandom_range(0, 1)) s.push_back($urandom_range(0, 1) ? "N" : "S");
		else if ($urandom_range(0, 3) == 0) s.push_back(junk_char());
		s.push_back(nggp_pkg::CH_COMMA);
		add_position(s, 5);
		s.push_back(nggp_pkg::CH_COMMA);
		// Break some sentences: cut short or restart midway
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, s.size() - 1);
			s = s[0:cut-1];
		end else if ($urandom_range(0, 14) == 0) begin
			s.insert($urandom_range(1, s.size() - 1), nggp_pkg::CH_DOLLAR);
		end
		// Tail fields and line noise, ignored outside a sentence
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 3) == 0) s.push_back(nggp_pkg::CH_COMMA);
				else s.push_back(junk_char());
			end
		end
		foreach (s[i]) char_queue.push_back(s[i]);
	endtask

	task automatic wait_idle();
		while (char_queue.size() > 0 || s_tvalid || expected_fixes.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: noise outside a sentence, extremes, short and broken fields
		add_text("zz,9");
		char_queue.push_back(8'hFF);
		char_queue.push_back(8'h00);
		add_text("$GPGGA,235959,9999.99999,N,99999.99999,E,1,08");
		add_text("$,12a4,,,,");
		add_text("$,0000009,1.2.345678,x,.5,W,");
		add_text("$,1$,000000,99999,,999999,,");
		wait_idle();

		for (int i = 0; i < 6; i++) add_sentence();
		wait_idle();

		steady = 1'b1;
		for (int i = 0; i < 5; i++) add_sentence();
		wait_idle();
		steady = 1'b0;

		// Short sentences pile up fixes while the receiver holds off
		for (int i = 0; i < 6; i++) add_text("$,010203,,,,");
		for (int i = 0; i < 6; i++) add_sentence();
		repeat (20) @(posedge clk);
		hold_start = 1'b1;
		wait_idle();

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
